// ----- src/mlpsk_pkg.sv -----
// Shared types, constants and codes for the skip-layer perceptron inference core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mlpsk_pkg;

  // Sizing
  localparam int MAX_FEATURES = 16;
  localparam int MAX_HIDDEN   = 16;
  localparam int MAX_LABELS   = 8;
  localparam int DATA_WIDTH   = 16;

  // Item field widths
  localparam int ROW_W  = 5;
  localparam int COL_W  = 4;
  localparam int LBL_W  = 3;
  localparam int ACT_W  = 24;
  localparam int PROB_W = 16;

  // Configuration register widths
  localparam int FCFG_W    = 5;
  localparam int HCFG_W    = 5;
  localparam int LCFG_W    = 4;
  localparam int LEAK_W    = 13;
  localparam int CFG_IDX_W = 2;

  // Derived widths
  localparam int FEAT_IW = $clog2(MAX_FEATURES);
  localparam int HID_IW  = $clog2(MAX_HIDDEN);
  localparam int FCNT_W  = $clog2(MAX_FEATURES + 1);
  localparam int HCNT_W  = $clog2(MAX_HIDDEN + 1);
  localparam int LCNT_W  = $clog2(MAX_LABELS + 1);

  localparam int HW_DEPTH = (MAX_FEATURES + 1) * MAX_HIDDEN;
  localparam int LW_DEPTH = (MAX_HIDDEN + 1) * MAX_LABELS;
  localparam int SW_DEPTH = (MAX_FEATURES + 1) * MAX_LABELS;
  localparam int HW_AW    = $clog2(HW_DEPTH);
  localparam int LW_AW    = $clog2(LW_DEPTH);
  localparam int SW_AW    = $clog2(SW_DEPTH);

  // Arithmetic
  localparam int ACC_W    = 40;
  localparam int FRAC     = 12;
  localparam int PROD_W   = 2 * DATA_WIDTH;
  localparam int LIN_W    = 18;
  localparam int NL_IN_W  = 24;
  localparam int NL_OUT_W = 17;

  // exp / divide constants, Q.16
  localparam int LOG2E_Q16  = 94548;
  localparam int HALF_Q16   = 32768;
  localparam int ONE_Q16    = 65536;
  localparam int POLY_C1    = 45426;
  localparam int POLY_C2    = 15742;
  localparam int POLY_C3    = 3087;
  localparam int PROB_MAX   = 65535;
  localparam int DIV_STEPS  = 34;
  localparam int SHIFT_LIM  = 32;

  // Item codes
  localparam logic MODE_WEIGHT  = 1'b0;
  localparam logic MODE_FEATURE = 1'b1;

  typedef enum logic [1:0] {
    LAYER_IH   = 2'd0,
    LAYER_HL   = 2'd1,
    LAYER_SKIP = 2'd2
  } layer_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEATURES = 2'd0,
    CFG_HIDDEN   = 2'd1,
    CFG_LABELS   = 2'd2,
    CFG_LEAK     = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_H_MAC,
    ST_H_DRAIN,
    ST_H_ROUND,
    ST_H_START,
    ST_H_WAIT,
    ST_H_STORE,
    ST_L_HID,
    ST_L_SKIP,
    ST_L_DRAIN,
    ST_L_ROUND,
    ST_L_START,
    ST_L_WAIT,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    NL_IDLE,
    NL_P1,
    NL_P2,
    NL_P3,
    NL_EXP,
    NL_DIV
  } nlu_state_e;

  // Controller to datapath
  typedef struct packed {
    logic             mac_en;
    layer_e           layer;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             bias;
    logic             first;
    logic             round_h;
    logic             round_l;
    logic             nl_start;
    logic             nl_tanh;
    logic             lin_en;
    logic             hv_wr;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [FCNT_W-1:0] p_eff;
    logic [HCNT_W-1:0] d_eff;
    logic [LCNT_W-1:0] k_eff;
    logic              nl_done;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- src/mlp_skip_layer_inference_core.sv -----
// Top level of the skip-layer perceptron inference core: ports and glue.
// Depends on mlpsk_pkg, mlpsk_ctrl, mlpsk_dp (and mlpsk_nlu beneath it).
//
//   channel | handshake                | words carried
//   --------+--------------------------+----------------------------------------------
//   in      | in_valid_i / in_ready_o  | mode, weight_layer, row/col index, value, eos
//   out     | out_valid_o / out_ready_i| label_index, activation, probability, last
//   cfg     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// Weight and feature words are accepted only while idle. A feature word with
// end_of_sample set starts inference: D hidden units, each a MAC pass over P
// features and bias then tanh, and K labels, each over D hidden values, P features
// and biases then sigmoid, share the MAC and the tanh/sigmoid unit's 34-step divider.
// No clearing pass after reset; the config port is always ready.
// A result sits in the output register until taken, the core stalling meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module mlp_skip_layer_inference_core import mlpsk_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [1:0]                   weight_layer_i,
  input  logic [ROW_W-1:0]             row_index_i,
  input  logic [COL_W-1:0]             col_index_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  input  logic                         end_of_sample_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [LBL_W-1:0]             label_index_o,
  output logic signed [ACT_W-1:0]      activation_o,
  output logic [PROB_W-1:0]            probability_o,
  output logic                         last_label_o,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [LEAK_W-1:0]            cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;

  mlpsk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_mode_i   (mode_i),
    .in_eos_i    (end_of_sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_label_o (label_index_o),
    .out_last_o  (last_label_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mlpsk_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .mode_i        (mode_i),
    .layer_i       (weight_layer_i),
    .row_i         (row_index_i),
    .col_i         (col_index_i),
    .value_i       (value_i),
    .cfg_we_i      (cfg_valid_i),
    .cfg_idx_i     (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .activation_o  (activation_o),
    .probability_o (probability_o)
  );

endmodule

`default_nettype wire

// ----- src/mlpsk_nlu.sv -----
// Multi-cycle tanh / sigmoid unit: exp(-v) by polynomial and shift, then a
// restoring divider one quotient bit per cycle. Depends on mlpsk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlpsk_nlu import mlpsk_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                tanh_i,
  input  logic                neg_i,
  input  logic [NL_IN_W-1:0]  mag_i,
  output logic                done_o,
  output logic [NL_OUT_W-1:0] res_o
);

  nlu_state_e state_q, state_d;

  logic [23:0] t_q;
  logic [16:0] p_q;
  logic        tanh_q, neg_q;
  logic [17:0] den_q;
  logic [33:0] quo_q;
  logic [16:0] rem_q;
  logic [5:0]  step_q;
  logic        done_q;
  logic [16:0] res_q;

  logic [40:0] t_prod;
  logic [15:0] f;
  logic [16:0] mul_op;
  logic [32:0] fp;
  logic [16:0] fp_hi;
  logic [11:0] n;
  logic [16:0] e;
  logic [16:0] num;
  logic [17:0] den;
  logic [33:0] dividend;
  logic [17:0] trial;
  logic        ge;
  logic [33:0] quo_n;
  logic        last_step;

  always_comb begin
    t_prod   = 41'(mag_i) * 41'(LOG2E_Q16) + 41'(HALF_Q16);
    f        = {t_q[11:0], 4'b0000};
    mul_op   = (state_q == NL_P1) ? 17'(POLY_C3) : p_q;
    fp       = 33'(f) * 33'(mul_op);
    fp_hi    = fp[32:16];
    n        = t_q[23:12];
    e        = (32'(n) >= SHIFT_LIM) ? 17'd0 : (p_q >> n[4:0]);
    den      = 18'(ONE_Q16) + 18'(e);
    if (tanh_q) begin
      num = 17'(ONE_Q16) - e;
    end else if (neg_q) begin
      num = e;
    end else begin
      num = 17'(ONE_Q16);
    end
    dividend  = {1'b0, num, 16'h0000} + 34'(den >> 1);
    trial     = {rem_q, quo_q[33]};
    ge        = (trial >= den_q);
    quo_n     = {quo_q[32:0], ge};
    last_step = (32'(step_q) == DIV_STEPS - 1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      NL_IDLE: if (start_i) state_d = NL_P1;
      NL_P1:   state_d = NL_P2;
      NL_P2:   state_d = NL_P3;
      NL_P3:   state_d = NL_EXP;
      NL_EXP:  state_d = NL_DIV;
      NL_DIV:  if (last_step) state_d = NL_IDLE;
      default: state_d = NL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NL_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == NL_DIV) && last_step;
      if (state_q == NL_EXP) begin
        step_q <= '0;
      end else if (state_q == NL_DIV) begin
        step_q <= step_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      NL_IDLE: begin
        if (start_i) begin
          t_q    <= t_prod[39:16];
          tanh_q <= tanh_i;
          neg_q  <= neg_i;
        end
      end
      NL_P1: p_q <= 17'(POLY_C2) - fp_hi;
      NL_P2: p_q <= 17'(POLY_C1) - fp_hi;
      NL_P3: p_q <= 17'(ONE_Q16) - fp_hi;
      NL_EXP: begin
        den_q <= den;
        quo_q <= dividend;
        rem_q <= '0;
      end
      NL_DIV: begin
        rem_q <= ge ? 17'(trial - den_q) : trial[16:0];
        quo_q <= quo_n;
        if (last_step) begin
          // sigmoid tops out one below unity
          res_q <= (!tanh_q && quo_n[16]) ? 17'(PROB_MAX) : quo_n[16:0];
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ----- src/mlpsk_dp.sv -----
// Datapath: configuration registers, weight memories, feature and hidden
// buffers, the shared multiply-accumulate, rounding and the nonlinear unit.
// Depends on mlpsk_pkg and mlpsk_nlu.
`timescale 1ns / 1ps
`default_nettype none

module mlpsk_dp import mlpsk_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_fire_i,
  input  logic                         mode_i,
  input  logic [1:0]                   layer_i,
  input  logic [ROW_W-1:0]             row_i,
  input  logic [COL_W-1:0]             col_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [LEAK_W-1:0]            cfg_data_i,
  input  dp_cmd_t                      cmd_i,
  output dp_sts_t                      sts_o,
  output logic signed [ACT_W-1:0]      activation_o,
  output logic [PROB_W-1:0]            probability_o
);

  // configuration
  logic [FCFG_W-1:0] feat_cnt_q;
  logic [HCFG_W-1:0] hid_cnt_q;
  logic [LCFG_W-1:0] lab_cnt_q;
  logic [LEAK_W-1:0] leak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feat_cnt_q <= FCFG_W'(MAX_FEATURES);
      hid_cnt_q  <= HCFG_W'(MAX_HIDDEN);
      lab_cnt_q  <= LCFG_W'(MAX_LABELS);
      leak_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FEATURES: feat_cnt_q <= cfg_data_i[FCFG_W-1:0];
        CFG_HIDDEN:   hid_cnt_q  <= cfg_data_i[HCFG_W-1:0];
        CFG_LABELS:   lab_cnt_q  <= cfg_data_i[LCFG_W-1:0];
        CFG_LEAK:     leak_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // counts in use: zero acts as one, large values clip
  logic [FCNT_W-1:0] p_eff;
  logic [HCNT_W-1:0] d_eff;
  logic [LCNT_W-1:0] k_eff;

  always_comb begin
    if (feat_cnt_q == '0) begin
      p_eff = FCNT_W'(1);
    end else if (32'(feat_cnt_q) > MAX_FEATURES) begin
      p_eff = FCNT_W'(MAX_FEATURES);
    end else begin
      p_eff = FCNT_W'(feat_cnt_q);
    end
    if (hid_cnt_q == '0) begin
      d_eff = HCNT_W'(1);
    end else if (32'(hid_cnt_q) > MAX_HIDDEN) begin
      d_eff = HCNT_W'(MAX_HIDDEN);
    end else begin
      d_eff = HCNT_W'(hid_cnt_q);
    end
    if (lab_cnt_q == '0) begin
      k_eff = LCNT_W'(1);
    end else if (32'(lab_cnt_q) > MAX_LABELS) begin
      k_eff = LCNT_W'(MAX_LABELS);
    end else begin
      k_eff = LCNT_W'(lab_cnt_q);
    end
  end

  // write decode for loaded words
  logic hw_we, lw_we, sw_we, feat_we;
  logic [HW_AW-1:0] hw_waddr, hw_raddr;
  logic [LW_AW-1:0] lw_waddr, lw_raddr;
  logic [SW_AW-1:0] sw_waddr, sw_raddr;
  logic hw_re, lw_re, sw_re;

  always_comb begin
    hw_we   = 1'b0;
    lw_we   = 1'b0;
    sw_we   = 1'b0;
    feat_we = in_fire_i && (mode_i == MODE_FEATURE) && (32'(row_i) < MAX_FEATURES);
    if (in_fire_i && (mode_i == MODE_WEIGHT)) begin
      case (layer_e'(layer_i))
        LAYER_IH:   hw_we = (32'(row_i) <= MAX_FEATURES) && (32'(col_i) < MAX_HIDDEN);
        LAYER_HL:   lw_we = (32'(row_i) <= MAX_HIDDEN) && (32'(col_i) < MAX_LABELS);
        LAYER_SKIP: sw_we = (32'(row_i) <= MAX_FEATURES) && (32'(col_i) < MAX_LABELS);
        default: ;
      endcase
    end
    hw_waddr = HW_AW'(int'(row_i) * MAX_HIDDEN + int'(col_i));
    lw_waddr = LW_AW'(int'(row_i) * MAX_LABELS + int'(col_i));
    sw_waddr = SW_AW'(int'(row_i) * MAX_LABELS + int'(col_i));
    hw_raddr = HW_AW'(int'(cmd_i.row) * MAX_HIDDEN + int'(cmd_i.col));
    lw_raddr = LW_AW'(int'(cmd_i.row) * MAX_LABELS + int'(cmd_i.col));
    sw_raddr = SW_AW'(int'(cmd_i.row) * MAX_LABELS + int'(cmd_i.col));
    hw_re    = cmd_i.mac_en && (cmd_i.layer == LAYER_IH);
    lw_re    = cmd_i.mac_en && (cmd_i.layer == LAYER_HL);
    sw_re    = cmd_i.mac_en && (cmd_i.layer == LAYER_SKIP);
  end

  // weight memories
  logic signed [DATA_WIDTH-1:0] hw_mem [HW_DEPTH];
  logic signed [DATA_WIDTH-1:0] lw_mem [LW_DEPTH];
  logic signed [DATA_WIDTH-1:0] sw_mem [SW_DEPTH];
  logic signed [DATA_WIDTH-1:0] hw_rdata_q, lw_rdata_q, sw_rdata_q;

  always_ff @(posedge clk_i) begin
    if (hw_we) hw_mem[hw_waddr] <= value_i;
    if (hw_re) hw_rdata_q <= hw_mem[hw_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (lw_we) lw_mem[lw_waddr] <= value_i;
    if (lw_re) lw_rdata_q <= lw_mem[lw_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sw_we) sw_mem[sw_waddr] <= value_i;
    if (sw_re) sw_rdata_q <= sw_mem[sw_raddr];
  end

  // feature and hidden buffers
  logic signed [DATA_WIDTH-1:0] feat_q [MAX_FEATURES];
  logic signed [DATA_WIDTH-1:0] hv_q   [MAX_HIDDEN];
  logic signed [DATA_WIDTH-1:0] hv_d;

  always_ff @(posedge clk_i) begin
    if (feat_we) feat_q[row_i[FEAT_IW-1:0]] <= value_i;
    if (cmd_i.hv_wr) hv_q[cmd_i.col[HID_IW-1:0]] <= hv_d;
  end

  // MAC stage 1: operand alongside the memory read
  logic                         mac_vld_q, bias_q, first_q;
  layer_e                       layer_q;
  logic signed [DATA_WIDTH-1:0] op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_vld_q <= 1'b0;
      bias_q    <= 1'b0;
      first_q   <= 1'b0;
      layer_q   <= LAYER_IH;
    end else begin
      mac_vld_q <= cmd_i.mac_en;
      bias_q    <= cmd_i.bias;
      first_q   <= cmd_i.first;
      layer_q   <= cmd_i.layer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_en) begin
      op_q <= (cmd_i.layer == LAYER_HL) ? hv_q[cmd_i.row[HID_IW-1:0]]
                                        : feat_q[cmd_i.row[FEAT_IW-1:0]];
    end
  end

  // MAC stage 2
  logic signed [DATA_WIDTH-1:0] rdata;
  logic signed [PROD_W-1:0]     prod;
  logic signed [ACC_W-1:0]      prod_x;
  logic signed [ACC_W-1:0]      acc_q;

  always_comb begin
    case (layer_q)
      LAYER_IH:   rdata = hw_rdata_q;
      LAYER_HL:   rdata = lw_rdata_q;
      LAYER_SKIP: rdata = sw_rdata_q;
      default:    rdata = '0;
    endcase
    if (bias_q) begin
      prod = PROD_W'(rdata) <<< FRAC;
    end else begin
      prod = PROD_W'(op_q) * PROD_W'(rdata);
    end
    prod_x = ACC_W'(prod);
  end

  always_ff @(posedge clk_i) begin
    if (mac_vld_q) acc_q <= first_q ? prod_x : acc_q + prod_x;
  end

  // rounding of the sum, half up
  logic signed [ACC_W-1:0]      acc_rnd;
  logic signed [DATA_WIDTH-1:0] ha_sat, ha_q;
  logic signed [ACT_W-1:0]      act_sat, act_q;

  always_comb begin
    acc_rnd = (acc_q + ACC_W'(2 ** (FRAC - 1))) >>> FRAC;
    if (acc_rnd > ACC_W'(2 ** (DATA_WIDTH - 1) - 1)) begin
      ha_sat = DATA_WIDTH'(2 ** (DATA_WIDTH - 1) - 1);
    end else if (acc_rnd < -ACC_W'(2 ** (DATA_WIDTH - 1))) begin
      ha_sat = DATA_WIDTH'(-(2 ** (DATA_WIDTH - 1)));
    end else begin
      ha_sat = DATA_WIDTH'(acc_rnd);
    end
    if (acc_rnd > ACC_W'(2 ** (ACT_W - 1) - 1)) begin
      act_sat = ACT_W'(2 ** (ACT_W - 1) - 1);
    end else if (acc_rnd < -ACC_W'(2 ** (ACT_W - 1))) begin
      act_sat = ACT_W'(-(2 ** (ACT_W - 1)));
    end else begin
      act_sat = ACT_W'(acc_rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.round_h) ha_q  <= ha_sat;
    if (cmd_i.round_l) act_q <= act_sat;
  end

  // leak term
  logic signed [29:0]    lin_prod;
  logic signed [LIN_W-1:0] lin_q;

  assign lin_prod = 30'(signed'({1'b0, leak_q})) * 30'(ha_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.lin_en) lin_q <= LIN_W'((lin_prod + 30'sd2048) >>> FRAC);
  end

  // nonlinear unit
  logic signed [16:0]   ha_x;
  logic [16:0]          ha_abs;
  logic signed [24:0]   act_x;
  logic [24:0]          act_abs;
  logic [NL_IN_W-1:0]   nl_mag;
  logic                 nl_done;
  logic [NL_OUT_W-1:0]  nl_res;

  always_comb begin
    ha_x    = 17'(ha_q);
    ha_abs  = ha_x[16] ? 17'(-ha_x) : 17'(ha_x);
    act_x   = 25'(act_q);
    act_abs = act_x[24] ? 25'(-act_x) : 25'(act_x);
    nl_mag  = cmd_i.nl_tanh ? NL_IN_W'({ha_abs, 1'b0}) : act_abs[NL_IN_W-1:0];
  end

  mlpsk_nlu u_nlu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.nl_start),
    .tanh_i  (cmd_i.nl_tanh),
    .neg_i   (act_q[ACT_W-1]),
    .mag_i   (nl_mag),
    .done_o  (nl_done),
    .res_o   (nl_res)
  );

  // status back to the controller, fields in struct order
  assign sts_o = {p_eff, d_eff, k_eff, nl_done};

  // hidden value: tanh to Q.12 with the sign of the sum, plus leak
  logic [17:0]        th_rnd;
  logic signed [18:0] th_s, hv_sum;

  always_comb begin
    th_rnd = (18'(nl_res) + 18'd8) >> 4;
    th_s   = ha_q[DATA_WIDTH-1] ? -19'(th_rnd) : 19'(th_rnd);
    hv_sum = th_s + 19'(lin_q);
    if (hv_sum > 19'(2 ** (DATA_WIDTH - 1) - 1)) begin
      hv_d = DATA_WIDTH'(2 ** (DATA_WIDTH - 1) - 1);
    end else if (hv_sum < -19'(2 ** (DATA_WIDTH - 1))) begin
      hv_d = DATA_WIDTH'(-(2 ** (DATA_WIDTH - 1)));
    end else begin
      hv_d = DATA_WIDTH'(hv_sum);
    end
  end

  assign activation_o  = act_q;
  assign probability_o = nl_res[PROB_W-1:0];

endmodule

`default_nettype wire

// ----- src/mlpsk_ctrl.sv -----
// Controller: sequences loads, hidden-unit and label passes and result hand-off.
// Depends on mlpsk_pkg; drives mlpsk_dp through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module mlpsk_ctrl import mlpsk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             in_mode_i,
  input  logic             in_eos_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [LBL_W-1:0] out_label_o,
  output logic             out_last_o,
  output dp_cmd_t          cmd_o,
  input  dp_sts_t          sts_i
);

  ctrl_state_e      state_q, state_d;
  logic [ROW_W-1:0] cnt_q, cnt_d;
  logic [COL_W-1:0] unit_q, unit_d;

  logic at_p, at_d, last_hid, last_lab;

  always_comb begin
    at_p     = (cnt_q == ROW_W'(sts_i.p_eff));
    at_d     = (cnt_q == ROW_W'(sts_i.d_eff));
    last_hid = (HCNT_W'(unit_q) + HCNT_W'(1) == sts_i.d_eff);
    last_lab = (LCNT_W'(unit_q) + LCNT_W'(1) == sts_i.k_eff);
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unit_d  = unit_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_mode_i == MODE_FEATURE) && in_eos_i) begin
          state_d = ST_H_MAC;
          cnt_d   = '0;
          unit_d  = '0;
        end
      end
      ST_H_MAC: begin
        cnt_d = cnt_q + ROW_W'(1);
        if (at_p) state_d = ST_H_DRAIN;
      end
      ST_H_DRAIN: state_d = ST_H_ROUND;
      ST_H_ROUND: state_d = ST_H_START;
      ST_H_START: state_d = ST_H_WAIT;
      ST_H_WAIT:  if (sts_i.nl_done) state_d = ST_H_STORE;
      ST_H_STORE: begin
        cnt_d = '0;
        if (last_hid) begin
          unit_d  = '0;
          state_d = ST_L_HID;
        end else begin
          unit_d  = unit_q + COL_W'(1);
          state_d = ST_H_MAC;
        end
      end
      ST_L_HID: begin
        cnt_d = cnt_q + ROW_W'(1);
        if (at_d) begin
          cnt_d   = '0;
          state_d = ST_L_SKIP;
        end
      end
      ST_L_SKIP: begin
        cnt_d = cnt_q + ROW_W'(1);
        if (at_p) state_d = ST_L_DRAIN;
      end
      ST_L_DRAIN: state_d = ST_L_ROUND;
      ST_L_ROUND: state_d = ST_L_START;
      ST_L_START: state_d = ST_L_WAIT;
      ST_L_WAIT:  if (sts_i.nl_done) state_d = ST_OUT;
      ST_OUT: begin
        if (out_ready_i) begin
          cnt_d = '0;
          if (last_lab) begin
            state_d = ST_IDLE;
          end else begin
            unit_d  = unit_q + COL_W'(1);
            state_d = ST_L_HID;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.layer = LAYER_IH;
    cmd_o.row   = cnt_q;
    cmd_o.col   = unit_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_H_MAC: begin
        cmd_o.mac_en = 1'b1;
        cmd_o.bias   = at_p;
        cmd_o.first  = (cnt_q == '0);
      end
      ST_H_ROUND: cmd_o.round_h = 1'b1;
      ST_H_START: begin
        cmd_o.nl_start = 1'b1;
        cmd_o.nl_tanh  = 1'b1;
        cmd_o.lin_en   = 1'b1;
      end
      ST_H_STORE: cmd_o.hv_wr = 1'b1;
      ST_L_HID: begin
        cmd_o.mac_en = 1'b1;
        cmd_o.layer  = LAYER_HL;
        cmd_o.bias   = at_d;
        cmd_o.first  = (cnt_q == '0);
      end
      ST_L_SKIP: begin
        cmd_o.mac_en = 1'b1;
        cmd_o.layer  = LAYER_SKIP;
        cmd_o.bias   = at_p;
      end
      ST_L_ROUND: cmd_o.round_l = 1'b1;
      ST_L_START: cmd_o.nl_start = 1'b1;
      ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      unit_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      unit_q  <= unit_d;
    end
  end

  assign out_label_o = unit_q[LBL_W-1:0];
  assign out_last_o  = last_lab;

endmodule

`default_nettype wire

// ----- bench/mlp_skip_layer_inference_core_tb.sv -----
// Self-checking bench for the skip-layer perceptron inference core.
// Depends on mlpsk_pkg and the core; a built-in predictor checks every result word.
`timescale 1ns / 1ps

module mlp_skip_layer_inference_core_tb;
  import mlpsk_pkg::*;

  localparam int  SETTLE = 64;        // quiet cycles before a config write and at the end
  localparam int  LIMIT  = 1_000_000; // run-away guard, cycles
  localparam int  RAND_WORDS = 250;
  localparam int  DIR_ROWS   = 22;

  // DUT signals
  logic                         clk, rst_n;
  logic                         in_valid, in_ready;
  logic                         mode;
  logic [1:0]                   layer;
  logic [ROW_W-1:0]             row;
  logic [COL_W-1:0]             col;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         eos;
  logic                         out_valid, out_ready;
  logic [LBL_W-1:0]             label_idx;
  logic signed [ACT_W-1:0]      activation;
  logic [PROB_W-1:0]            probability;
  logic                         last_label;
  logic                         cfg_valid, cfg_ready;
  cfg_idx_e                     cfg_idx;
  logic [LEAK_W-1:0]            cfg_data;

  mlp_skip_layer_inference_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .weight_layer_i (layer),
    .row_index_i    (row),
    .col_index_i    (col),
    .value_i        (value),
    .end_of_sample_i(eos),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .label_index_o  (label_idx),
    .activation_o   (activation),
    .probability_o  (probability),
    .last_label_o   (last_label),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  typedef struct {
    logic [LBL_W-1:0]        lbl;
    logic signed [ACT_W-1:0] act;
    logic [PROB_W-1:0]       prob;
    logic                    last;
  } label_word_t;

  // Directed stimulus row; typed rows carry their own expected act/prob for every label
  typedef struct {
    logic                         mode;
    logic [1:0]                   layer;
    logic [ROW_W-1:0]             row;
    logic [COL_W-1:0]             col;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         eos;
    bit                           typed;
    logic signed [ACT_W-1:0]      act;
    logic [PROB_W-1:0]            prob;
  } stim_row_t;

  // Predictor state
  longint hid_w [MAX_FEATURES+1][MAX_HIDDEN];
  longint lab_w [MAX_HIDDEN+1][MAX_LABELS];
  longint skp_w [MAX_FEATURES+1][MAX_LABELS];
  longint feat  [MAX_FEATURES];
  longint hid_val [MAX_HIDDEN];
  int     n_feat, n_hid, n_lbl, leak;

  label_word_t label_q [$];
  int  idle_mode;    // 0 none, 1 sender, 2 receiver, 3 both
  int  errors, results_seen, samples_run, words_sent;
  longint cycles;

  // Clock, reset, run-away guard
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver stalls according to the current idling phase
  always @(posedge clk) begin
    if (idle_mode == 2)      out_ready <= ($urandom_range(0, 99) >= 58);
    else if (idle_mode == 3) out_ready <= ($urandom_range(0, 99) >= 15);
    else                     out_ready <= 1'b1;
  end

  // Result checker: oldest expectation against each accepted word
  always @(posedge clk) begin
    label_word_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (label_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected label word lbl=%0d act=%0d", $time, label_idx, activation);
      end else begin
        e = label_q.pop_front();
        if (label_idx !== e.lbl) begin
          errors++;
          $display("%0t: label index exp %0d got %0d", $time, e.lbl, label_idx);
        end
        if (activation !== e.act) begin
          errors++;
          $display("%0t: activation lbl %0d exp %0d got %0d", $time, e.lbl, e.act, activation);
        end
        if (probability !== e.prob) begin
          errors++;
          $display("%0t: probability lbl %0d exp %0d got %0d", $time, e.lbl, e.prob,
                   probability);
        end
        if (last_label !== e.last) begin
          errors++;
          $display("%0t: last flag lbl %0d exp %0b got %0b", $time, e.lbl, e.last, last_label);
        end
      end
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int eff_count(int c, int mx);
    if (c == 0) return 1;
    return (c > mx) ? mx : c;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic longint to_q12(longint v);
    return (v + 2048) >>> FRAC;
  endfunction

  // exp(-v), v in Q.12, result Q.16 via 2^-t and a cubic on the fraction
  function automatic longint unsigned exp_neg_q16(longint unsigned v);
    longint unsigned t, n, f, p;
    t = (v * LOG2E_Q16 + HALF_Q16) >> 16;
    n = t >> FRAC;
    f = (t & 4095) << 4;
    p = POLY_C2 - ((f * POLY_C3) >> 16);
    p = POLY_C1 - ((f * p) >> 16);
    p = ONE_Q16 - ((f * p) >> 16);
    if (n >= SHIFT_LIM) return 0;
    return p >> n;
  endfunction

  function automatic longint unsigned tanh_q16(longint unsigned u);
    longint unsigned e, den;
    e   = exp_neg_q16(2 * u);
    den = ONE_Q16 + e;
    return (((ONE_Q16 - e) << 16) + den / 2) / den;
  endfunction

  function automatic longint unsigned sigmoid_q16(longint a);
    longint unsigned mag, e, den, num, s;
    mag = (a < 0) ? longint'(-a) : a;
    e   = exp_neg_q16(mag);
    den = ONE_Q16 + e;
    num = (a < 0) ? e : ONE_Q16;
    s   = ((num << 16) + den / 2) / den;
    return (s > PROB_MAX) ? PROB_MAX : s;
  endfunction

  // Applies one accepted word to the predictor; a sample end queues its label words
  task automatic absorb_word(logic m, logic [1:0] ly, int r, int c,
                             logic signed [DATA_WIDTH-1:0] v, logic e);
    int p, d, k;
    longint acc, ha, th, lin, a;
    longint unsigned mg;
    label_word_t w;
    if (m == MODE_WEIGHT) begin
      if (ly == LAYER_IH && r <= MAX_FEATURES && c < MAX_HIDDEN)        hid_w[r][c] = v;
      else if (ly == LAYER_HL && r <= MAX_HIDDEN && c < MAX_LABELS)     lab_w[r][c] = v;
      else if (ly == LAYER_SKIP && r <= MAX_FEATURES && c < MAX_LABELS) skp_w[r][c] = v;
      return;
    end
    if (r < MAX_FEATURES) feat[r] = v;
    if (!e) return;
    samples_run++;
    p = eff_count(n_feat, MAX_FEATURES);
    d = eff_count(n_hid, MAX_HIDDEN);
    k = eff_count(n_lbl, MAX_LABELS);
    for (int j = 0; j < d; j++) begin
      acc = hid_w[p][j] * 4096;
      for (int i = 0; i < p; i++) acc += feat[i] * hid_w[i][j];
      ha  = clamp(to_q12(acc), DATA_WIDTH);
      mg  = (tanh_q16((ha < 0) ? -ha : ha) + 8) >> 4;
      th  = (ha < 0) ? -longint'(mg) : longint'(mg);
      lin = to_q12(longint'(leak) * ha);
      hid_val[j] = clamp(th + lin, DATA_WIDTH);
    end
    for (int q = 0; q < k; q++) begin
      acc = (lab_w[d][q] + skp_w[p][q]) * 4096;
      for (int j = 0; j < d; j++) acc += hid_val[j] * lab_w[j][q];
      for (int i = 0; i < p; i++) acc += feat[i] * skp_w[i][q];
      a      = clamp(to_q12(acc), ACT_W);
      w.lbl  = LBL_W'(q);
      w.act  = ACT_W'(a);
      w.prob = PROB_W'(sigmoid_q16(a));
      w.last = (q + 1 == k);
      label_q.push_back(w);
    end
  endtask

  // ---------------------------------------------------------------- drivers

  // Sender: optional idle gap, then hold the word until taken
  task automatic send_word(logic m, logic [1:0] ly, logic [ROW_W-1:0] r,
                           logic [COL_W-1:0] c, logic signed [DATA_WIDTH-1:0] v, logic e);
    int pct;
    pct = (idle_mode == 1) ? 58 : ((idle_mode == 3) ? 15 : 0);
    while ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    layer    <= ly;
    row      <= r;
    col      <= c;
    value    <= v;
    eos      <= e;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    absorb_word(m, ly, int'(r), int'(c), v, e);
  endtask

  // Waits until every label word is back and the core has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (label_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(int f, int h, int l, int lk);
    int vals [4];
    vals = '{f, h, l, lk};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_idx   <= cfg_idx_e'(i);
      cfg_data  <= LEAK_W'(vals[i]);
      do @(posedge clk); while (!cfg_ready);
      case (cfg_idx_e'(i))
        CFG_FEATURES: n_feat = vals[i] & 31;
        CFG_HIDDEN:   n_hid  = vals[i] & 31;
        CFG_LABELS:   n_lbl  = vals[i] & 15;
        CFG_LEAK:     leak   = vals[i] & 8191;
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] rand_value();
    if ($urandom_range(0, 3) == 0) return DATA_WIDTH'($urandom);
    return DATA_WIDTH'($urandom_range(0, 8191) - 4096);
  endfunction

  // One sample: a few weight updates, the feature loads, end of sample on the last;
  // now and then noise words (bad addresses, layer three, stray end flags)
  task automatic random_sample();
    int p;
    p = eff_count(n_feat, MAX_FEATURES);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 7) == 0)
        send_word(MODE_WEIGHT, 2'($urandom_range(0, 3)), ROW_W'($urandom_range(0, 31)),
                  COL_W'($urandom_range(0, 15)), DATA_WIDTH'($urandom),
                  1'($urandom_range(0, 1)));
      else
        case ($urandom_range(0, 2))
          0: send_word(MODE_WEIGHT, LAYER_IH, ROW_W'($urandom_range(0, MAX_FEATURES)),
                       COL_W'($urandom_range(0, MAX_HIDDEN - 1)), rand_value(), 1'b0);
          1: send_word(MODE_WEIGHT, LAYER_HL, ROW_W'($urandom_range(0, MAX_HIDDEN)),
                       COL_W'($urandom_range(0, MAX_LABELS - 1)), rand_value(), 1'b0);
          default: send_word(MODE_WEIGHT, LAYER_SKIP, ROW_W'($urandom_range(0, MAX_FEATURES)),
                             COL_W'($urandom_range(0, MAX_LABELS - 1)), rand_value(), 1'b0);
        endcase
    end
    if ($urandom_range(0, 9) == 0)
      send_word(MODE_FEATURE, 2'($urandom_range(0, 3)), ROW_W'($urandom_range(MAX_FEATURES, 31)),
                COL_W'($urandom), DATA_WIDTH'($urandom), 1'($urandom_range(0, 1)));
    for (int i = 0; i < p; i++)
      send_word(MODE_FEATURE, 2'($urandom_range(0, 3)), ROW_W'(i), COL_W'($urandom),
                rand_value(), i == p - 1);
  endtask

  // ---------------------------------------------------------------- directed table

  // Rows flagged typed run with every weight at zero: act 0, sigmoid one half
  stim_row_t dir_tab [DIR_ROWS] = '{
    '{MODE_FEATURE, 2'd0,       5'd0,  4'd0,  16'sh7FFF, 1'b1, 1, 24'sd0, 16'd32768},
    '{MODE_FEATURE, 2'd3,       5'd15, 4'd15, 16'sh8000, 1'b1, 1, 24'sd0, 16'd32768},
    '{MODE_FEATURE, 2'd0,       5'd16, 4'd0,  16'sh1234, 1'b1, 1, 24'sd0, 16'd32768},
    '{MODE_WEIGHT,  LAYER_SKIP, 5'd16, 4'd0,  16'sh7FFF, 1'b1, 0, 24'sd0, 16'd0},
    '{MODE_WEIGHT,  LAYER_SKIP, 5'd16, 4'd1,  16'sh8000, 1'b0, 0, 24'sd0, 16'd0},
    '{MODE_WEIGHT,  LAYER_HL,   5'd16, 4'd2,  16'sh1000, 1'b0, 0, 24'sd0, 16'd0},
    '{MODE_WEIGHT,  LAYER_IH,   5'd16, 4'd0,  16'sh7FFF, 1'b0, 0, 24'sd0, 16'd0},
    '{MODE_WEIGHT,  LAYER_IH,   5'd16, 4'd1,  16'sh8000, 1'b0, 0, 24'sd0, 16'd0},
    '{MODE_WEIGHT,  LAYER_HL,   5'd0,  4'd3,  16'sh7FFF, 1'b0, 0, 24'sd0, 16'd0},
    '{MODE_WEIGHT,  LAYER_HL,   5'd1,  4'd3,  16'sh7FFF, 1'b0, 0, 24'sd0, 16'd0},
    '{MODE_WEIGHT,  2'd3,       5'd0,  4'd0,  16'sh5555, 1'b0, 0, 24'sd0, 16'd0},
    '{MODE_WEIGHT,  LAYER_IH,   5'd17, 4'd0,  16'sh5555, 1'b0, 0, 24'sd0, 16'd0},
    '{MODE_WEIGHT,  LAYER_HL,   5'd17, 4'd0,  16'sh5555, 1'b0, 0, 24'sd0, 16'd0},
    '{MODE_WEIGHT,  LAYER_HL,   5'd0,  4'd8,  16'sh5555, 1'b0, 0, 24'sd0, 16'd0},
    '{MODE_WEIGHT,  LAYER_SKIP, 5'd0,  4'd15, 16'sh5555, 1'b0, 0, 24'sd0, 16'd0},
    '{MODE_WEIGHT,  LAYER_IH,   5'd31, 4'd15, 16'sh5555, 1'b1, 0, 24'sd0, 16'd0},
    '{MODE_WEIGHT,  LAYER_IH,   5'd0,  4'd15, 16'sh0800, 1'b0, 0, 24'sd0, 16'd0},
    '{MODE_FEATURE, 2'd0,       5'd0,  4'd0,  16'sh7FFF, 1'b0, 0, 24'sd0, 16'd0},
    '{MODE_FEATURE, 2'd0,       5'd1,  4'd0,  16'sh8000, 1'b1, 0, 24'sd0, 16'd0},
    '{MODE_WEIGHT,  LAYER_SKIP, 5'd0,  4'd4,  16'sh8000, 1'b0, 0, 24'sd0, 16'd0},
    '{MODE_FEATURE, 2'd0,       5'd0,  4'd0,  16'sh8000, 1'b1, 0, 24'sd0, 16'd0},
    '{MODE_FEATURE, 2'd0,       5'd31, 4'd0,  16'sh0001, 1'b1, 0, 24'sd0, 16'd0}
  };

  // Settings per random phase: extremes, zero counts, over-range counts, mid values
  int phase_cfg [5][4] = '{
    '{0,  0,  0,  4096},
    '{31, 31, 15, 8191},
    '{1,  1,  1,  0},
    '{5,  7,  3,  2048},
    '{16, 16, 8,  1}
  };

  // ---------------------------------------------------------------- sequence

  initial begin
    int qlen, rand_start;
    rst_n = 1'b0;
    in_valid = 1'b0; mode = 1'b0; layer = '0; row = '0; col = '0; value = '0; eos = 1'b0;
    out_ready = 1'b1; cfg_valid = 1'b0; cfg_idx = CFG_FEATURES; cfg_data = '0;
    cycles = 0; errors = 0; results_seen = 0; samples_run = 0; words_sent = 0;
    idle_mode = 0;
    n_feat = MAX_FEATURES; n_hid = MAX_HIDDEN; n_lbl = MAX_LABELS; leak = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero every store entry and feature so that no inference reads an unwritten word
    for (int r = 0; r <= MAX_FEATURES; r++)
      for (int c = 0; c < MAX_HIDDEN; c++)
        send_word(MODE_WEIGHT, LAYER_IH, ROW_W'(r), COL_W'(c), '0, 1'b0);
    for (int r = 0; r <= MAX_HIDDEN; r++)
      for (int c = 0; c < MAX_LABELS; c++)
        send_word(MODE_WEIGHT, LAYER_HL, ROW_W'(r), COL_W'(c), '0, 1'b0);
    for (int r = 0; r <= MAX_FEATURES; r++)
      for (int c = 0; c < MAX_LABELS; c++)
        send_word(MODE_WEIGHT, LAYER_SKIP, ROW_W'(r), COL_W'(c), '0, 1'b0);
    for (int i = 0; i < MAX_FEATURES; i++)
      send_word(MODE_FEATURE, LAYER_IH, ROW_W'(i), '0, '0, 1'b0);

    // Directed part, reset configuration
    foreach (dir_tab[n]) begin
      qlen = label_q.size();
      send_word(dir_tab[n].mode, dir_tab[n].layer, dir_tab[n].row, dir_tab[n].col,
                dir_tab[n].value, dir_tab[n].eos);
      if (dir_tab[n].typed)
        for (int q = qlen; q < label_q.size(); q++) begin
          label_q[q].act  = dir_tab[n].act;
          label_q[q].prob = dir_tab[n].prob;
        end
    end
    drain();

    // Random phases, each under its own setting and one of the four idling patterns
    for (int ph = 0; ph < 5; ph++) begin
      write_cfg(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2], phase_cfg[ph][3]);
      idle_mode  = ph % 4;
      rand_start = words_sent;
      while (words_sent - rand_start < RAND_WORDS / 5) random_sample();
      drain();
    end

    $display("%0d samples inferred, %0d label words checked, %0d input words sent",
             samples_run, results_seen, words_sent);
    $display("counts from zero to over-range, leak from 0 to 8191, four idling patterns");
    if (errors == 0) $display("end of test: clean");
    else             $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/mlpsk_pkg.sv
src/mlpsk_nlu.sv
src/mlpsk_dp.sv
src/mlpsk_ctrl.sv
src/mlp_skip_layer_inference_core.sv
bench/mlp_skip_layer_inference_core_tb.sv
